// ===== rtl/utf8_decode_to_codepage_top_defines.svh =====
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Assertion forms used by the decoder byte stage.
// ---------------------------------------------------------------------------
`ifndef UTF8_DECODE_TO_CODEPAGE_TOP_DEFINES_SVH
`define UTF8_DECODE_TO_CODEPAGE_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define U8D_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/u8d_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder package
// Types, constants and the code-page lookup shared by the decoder modules.
// ---------------------------------------------------------------------------
package u8d_pkg;

   localparam int unsigned CsrAddrWidth = 1;
   localparam logic [CsrAddrWidth-1:0] RegMapEnable = 1'b0;

   localparam logic [7:0]  MissCode   = 8'hfe;
   localparam logic [15:0] CpNoncharLo = 16'hfffe;
   localparam logic [15:0] CpBom       = 16'hfeff;
   localparam logic [15:0] CpSpaceLo   = 16'h200a;
   localparam logic [15:0] CpSpaceHi   = 16'h200f;

   typedef logic [2:0] count_type;

   // decoder state handed to the output stage
   typedef struct packed {
      logic        emit;
      logic [15:0] code_point;
      logic [7:0]  first_byte;
   } cand_type;

   // code-page lookup: below 0x80 is identity, table hit, else miss code
   function automatic logic [7:0] lookup_code(input logic [15:0] cp);
      logic [7:0] r;
      r = MissCode;
      if (cp < 16'h0080) begin
         r = cp[7:0];
      end else begin
         case (cp)
            16'h201d: r = 8'h22; 16'h2019: r = 8'h27; 16'h201a: r = 8'h2c;
            16'h0326: r = 8'h2c; 16'h2212: r = 8'h2d; 16'h2010: r = 8'h2d;
            16'h2013: r = 8'h2d; 16'h2014: r = 8'h2d; 16'h2015: r = 8'h2d;
            16'h2044: r = 8'h2f; 16'h00c0: r = 8'h41; 16'h00c1: r = 8'h41;
            16'h00c2: r = 8'h41; 16'h00c3: r = 8'h41; 16'h00c8: r = 8'h45;
            16'h00ca: r = 8'h45; 16'h00cb: r = 8'h45; 16'h00cc: r = 8'h49;
            16'h00cd: r = 8'h49; 16'h00ce: r = 8'h49; 16'h00cf: r = 8'h49;
            16'h0300: r = 8'h60; 16'h00a2: r = 8'h63; 16'h00a6: r = 8'h7c;
            16'h02dc: r = 8'h7e; 16'h0303: r = 8'h7e;
            16'h00c7: r = 8'h80; 16'h00fc: r = 8'h81; 16'h00e9: r = 8'h82;
            16'h00e2: r = 8'h83; 16'h00e4: r = 8'h84; 16'h00e0: r = 8'h85;
            16'h00e5: r = 8'h86; 16'h00e7: r = 8'h87; 16'h00ea: r = 8'h88;
            16'h00eb: r = 8'h89; 16'h00e8: r = 8'h8a; 16'h00ef: r = 8'h8b;
            16'h00ee: r = 8'h8c; 16'h00ec: r = 8'h8d; 16'h00c4: r = 8'h8e;
            16'h00c5: r = 8'h8f; 16'h212b: r = 8'h8f;
            16'h00c9: r = 8'h90; 16'h00e6: r = 8'h91; 16'h00c6: r = 8'h92;
            16'h00f4: r = 8'h93; 16'h00f6: r = 8'h94; 16'h00f2: r = 8'h95;
            16'h00fb: r = 8'h96; 16'h00f9: r = 8'h97; 16'h00ff: r = 8'h98;
            16'h00d6: r = 8'h99; 16'h00dc: r = 8'h9a; 16'h20ac: r = 8'h9b;
            16'h20a0: r = 8'h9b; 16'h00a4: r = 8'h9b; 16'h00a3: r = 8'h9c;
            16'h00a5: r = 8'h9d; 16'h20a7: r = 8'h9e; 16'h0192: r = 8'h9f;
            16'h00e1: r = 8'ha0; 16'h00ed: r = 8'ha1; 16'h00f3: r = 8'ha2;
            16'h00fa: r = 8'ha3; 16'h00f1: r = 8'ha4; 16'h00d1: r = 8'ha5;
            16'h00aa: r = 8'ha6; 16'h00ba: r = 8'ha7; 16'h00bf: r = 8'ha8;
            16'h2310: r = 8'ha9; 16'h00ac: r = 8'haa; 16'h00bd: r = 8'hab;
            16'h00bc: r = 8'hac; 16'h00a1: r = 8'had; 16'h00ab: r = 8'hae;
            16'h2039: r = 8'hae; 16'h2018: r = 8'hae; 16'h201c: r = 8'hae;
            16'h201e: r = 8'hae; 16'h00bb: r = 8'haf; 16'h203a: r = 8'haf;
            16'h2591: r = 8'hb0; 16'h2592: r = 8'hb1; 16'h2593: r = 8'hb2;
            16'h2502: r = 8'hb3; 16'h2524: r = 8'hb4; 16'h2561: r = 8'hb5;
            16'h2562: r = 8'hb6; 16'h2556: r = 8'hb7; 16'h2555: r = 8'hb8;
            16'h2563: r = 8'hb9; 16'h2551: r = 8'hba; 16'h2557: r = 8'hbb;
            16'h255d: r = 8'hbc; 16'h255c: r = 8'hbd; 16'h255b: r = 8'hbe;
            16'h2510: r = 8'hbf; 16'h2514: r = 8'hc0; 16'h2534: r = 8'hc1;
            16'h252c: r = 8'hc2; 16'h251c: r = 8'hc3; 16'h2500: r = 8'hc4;
            16'h253c: r = 8'hc5; 16'h255e: r = 8'hc6; 16'h255f: r = 8'hc7;
            16'h255a: r = 8'hc8; 16'h2554: r = 8'hc9; 16'h2569: r = 8'hca;
            16'h2566: r = 8'hcb; 16'h2560: r = 8'hcc; 16'h2550: r = 8'hcd;
            16'h256c: r = 8'hce; 16'h2567: r = 8'hcf; 16'h2568: r = 8'hd0;
            16'h2564: r = 8'hd1; 16'h2565: r = 8'hd2; 16'h2559: r = 8'hd3;
            16'h2558: r = 8'hd4; 16'h2552: r = 8'hd5; 16'h2553: r = 8'hd6;
            16'h256b: r = 8'hd7; 16'h256a: r = 8'hd8; 16'h2518: r = 8'hd9;
            16'h250c: r = 8'hda; 16'h2588: r = 8'hdb; 16'h2584: r = 8'hdc;
            16'h258c: r = 8'hdd; 16'h2590: r = 8'hde; 16'h2580: r = 8'hdf;
            16'h03b1: r = 8'he0; 16'h00df: r = 8'he1; 16'h03b2: r = 8'he1;
            16'h0393: r = 8'he2; 16'h03c0: r = 8'he3; 16'h03a3: r = 8'he4;
            16'h03c3: r = 8'he5; 16'h03bc: r = 8'he6; 16'h00b5: r = 8'he6;
            16'h03c4: r = 8'he7; 16'h03a6: r = 8'he8; 16'h0398: r = 8'he9;
            16'h03a9: r = 8'hea; 16'h2126: r = 8'hea; 16'h03b4: r = 8'heb;
            16'h221e: r = 8'hec; 16'h03c6: r = 8'hed; 16'h2205: r = 8'hed;
            16'h2300: r = 8'hed; 16'h03b5: r = 8'hee; 16'h2208: r = 8'hee;
            16'h2229: r = 8'hef;
            16'h2261: r = 8'hf0; 16'h00b1: r = 8'hf1; 16'h2265: r = 8'hf2;
            16'h2264: r = 8'hf3; 16'h2320: r = 8'hf4; 16'h2321: r = 8'hf5;
            16'h00f7: r = 8'hf6; 16'h2248: r = 8'hf7; 16'h00b0: r = 8'hf8;
            16'h02da: r = 8'hf8; 16'h030a: r = 8'hf8; 16'h2219: r = 8'hf9;
            16'h00b7: r = 8'hfa; 16'h221a: r = 8'hfb; 16'h207f: r = 8'hfc;
            16'h00b2: r = 8'hfd; 16'h25a0: r = 8'hfe; 16'h00a0: r = 8'hff;
            default: r = MissCode;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/u8d_stream_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder stream interfaces
// Valid/ready channels for input bytes and decoded characters.
// ---------------------------------------------------------------------------
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_point;
   logic [7:0]  mapped_code;
   modport source (output valid, output code_point, output mapped_code, input ready);
   modport sink (input valid, input code_point, input mapped_code, output ready);
endinterface

// ===== rtl/u8d_decode.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder byte stage
// Registers the accepted byte, decodes it against the sequence state.
// ---------------------------------------------------------------------------
`include "utf8_decode_to_codepage_top_defines.svh"

module u8d_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              adv,
   output logic              in_ready,
   output u8d_pkg::cand_type cand
);
   import u8d_pkg::*;

   logic        byte_vld_ff, byte_vld_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  rem_ff, rem_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  held_ff, held_in;
   logic        held_vld_ff, held_vld_in;
   logic [7:0]  first;
   logic [15:0] cp;
   logic        cand_ok;
   logic        supp;

   // input register empties whenever downstream can take a candidate
   assign in_ready = !byte_vld_ff || adv;
   assign byte_vld_in = in_ready ? in_valid : byte_vld_ff;
   assign byte_in = (in_ready && in_valid) ? in_byte : byte_ff;

   // decode the registered byte
   always_comb begin
      rem_in = rem_ff;
      acc_in = acc_ff;
      cp = acc_ff;
      cand_ok = 1'b0;
      first = held_vld_ff ? held_ff : byte_ff;
      if (byte_ff[7] == 1'b0) begin
         cp = {8'h00, byte_ff};
         rem_in = '0;
         cand_ok = 1'b1;
      end else if (rem_ff != 3'd0 && byte_ff[7:6] == 2'b10) begin
         acc_in = {acc_ff[9:0], byte_ff[5:0]};
         rem_in = rem_ff - 3'd1;
         cp = acc_in;
         cand_ok = (rem_in == 3'd0);
      end else if (byte_ff[7:5] == 3'b110) begin
         rem_in = 3'd1; acc_in = {11'd0, byte_ff[4:0]};
      end else if (byte_ff[7:4] == 4'b1110) begin
         rem_in = 3'd2; acc_in = {12'd0, byte_ff[3:0]};
      end else if (byte_ff[7:3] == 5'b11110) begin
         rem_in = 3'd3; acc_in = {13'd0, byte_ff[2:0]};
      end else if (byte_ff[7:2] == 6'b111110) begin
         rem_in = 3'd4; acc_in = {14'd0, byte_ff[1:0]};
      end else if (byte_ff[7:1] == 7'b1111110) begin
         rem_in = 3'd5; acc_in = {15'd0, byte_ff[0]};
      end else begin
         rem_in = '0;
      end
      supp = (cp == 16'd0) || (cp >= CpNoncharLo) || (cp == CpBom) ||
             (cp >= CpSpaceLo && cp <= CpSpaceHi);
      cand.emit = byte_vld_ff && cand_ok && !supp;
      cand.code_point = cp;
      cand.first_byte = first;
      held_in = first;
      held_vld_in = !cand.emit;
   end

   // state advances when the registered byte moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         rem_ff <= '0;
         acc_ff <= '0;
         held_ff <= '0;
         held_vld_ff <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         if (byte_vld_ff && adv) begin
            rem_ff <= rem_in;
            acc_ff <= acc_in;
            held_ff <= held_in;
            held_vld_ff <= held_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   `U8D_ASSERT_IMPL(a_rem_range, clock, reset, 1'b1, rem_ff <= 3'd5)
   `U8D_ASSERT_NEXT(a_emit_releases, clock, reset, cand.emit && adv, !held_vld_ff)
   `U8D_ASSERT_IMPL(a_ascii_clears, clock, reset,
      byte_vld_ff && !byte_ff[7], rem_in == 3'd0)
endmodule

// ===== rtl/u8d_output.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder result stage
// Code-page lookup and the result register toward the sink.
// ---------------------------------------------------------------------------
module u8d_output (
   input  logic              clock,
   input  logic              reset,
   input  u8d_pkg::cand_type cand,
   input  logic              map_enable,
   output logic              adv,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [15:0]       code_point,
   output logic [7:0]        mapped_code
);
   import u8d_pkg::*;

   logic        vld_ff;
   logic [15:0] cp_ff;
   logic [7:0]  code_ff;

   // result register is free when empty or being drained
   assign adv = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign code_point = cp_ff;
   assign mapped_code = code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= cand.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && cand.emit) begin
         cp_ff <= cand.code_point;
         code_ff <= map_enable ? lookup_code(cand.code_point) : cand.first_byte;
      end
   end
endmodule

// ===== rtl/utf8_decode_to_codepage_top.sv =====
// ---------------------------------------------------------------------------
// UTF-8 to code-page decoder
// Decodes a UTF-8 byte stream into 16-bit characters with a code-page byte.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while the result side takes results. A character
// passes the input register, then the result register, once its last byte is
// accepted. Throughput is one item per cycle on that condition. Register 0 at
// byte address 0, bit 0, selects table mapping (1, reset) or first raw byte.
module utf8_decode_to_codepage_top (
   input  logic        clock,
   input  logic        reset,
   u8d_req_if.sink     req,
   u8d_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [u8d_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import u8d_pkg::*;

   logic     map_en_ff;
   logic     adv;
   cand_type cand;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegMapEnable) ? {31'd0, map_en_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_en_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegMapEnable) begin
         map_en_ff <= csr_pwdata[0];
      end
   end

   u8d_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_byte  (req.in_byte),
      .adv      (adv),
      .in_ready (req.ready),
      .cand     (cand)
   );

   u8d_output u_output (
      .clock       (clock),
      .reset       (reset),
      .cand        (cand),
      .map_enable  (map_en_ff),
      .adv         (adv),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .code_point  (rsp.code_point),
      .mapped_code (rsp.mapped_code)
   );
endmodule

// ===== tb/sv/utf8_decode_to_codepage_top_checker.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder result checker
// Watches the byte and character channels, predicts each character from the
// accepted bytes and compares it field by field with what the block sends.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_decode_to_codepage_top_checker (
   input  logic        clock,
   input  logic        reset,
   u8d_req_if          req,
   u8d_rsp_if          rsp,
   input  logic        map_enable,
   output int          fail_count,
   output int          pending_count
);
   import u8d_pkg::*;

   typedef struct packed {
      logic [15:0] code_point;
      logic [7:0]  mapped_code;
   } char_type;

   char_type    char_queue[$];
   count_type   bytes_left;
   logic [15:0] accum;
   logic [7:0]  held_byte;
   logic        held_valid;

   // code-page table; below 0x80 is identity, a miss gives the miss code
   function automatic logic [7:0] codepage_of(input logic [15:0] cp);
      logic [15:0] keys[170];
      logic [7:0]  vals[170];
      keys = '{
         16'h201d, 16'h2019, 16'h201a, 16'h0326, 16'h2212, 16'h2010, 16'h2013,
         16'h2014, 16'h2015, 16'h2044, 16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3,
         16'h00c8, 16'h00ca, 16'h00cb, 16'h00cc, 16'h00cd, 16'h00ce, 16'h00cf,
         16'h0300, 16'h00a2, 16'h00a6, 16'h02dc, 16'h0303,
         16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5,
         16'h00e7, 16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec,
         16'h00c4, 16'h00c5, 16'h212b,
         16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb,
         16'h00f9, 16'h00ff, 16'h00d6, 16'h00dc, 16'h20ac, 16'h20a0, 16'h00a4,
         16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
         16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa,
         16'h00ba, 16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1,
         16'h00ab, 16'h2039, 16'h2018, 16'h201c, 16'h201e, 16'h00bb, 16'h203a,
         16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562,
         16'h2556, 16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c,
         16'h255b, 16'h2510, 16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500,
         16'h253c, 16'h255e, 16'h255f, 16'h255a, 16'h2554, 16'h2569, 16'h2566,
         16'h2560, 16'h2550, 16'h256c, 16'h2567, 16'h2568, 16'h2564, 16'h2565,
         16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b, 16'h256a, 16'h2518,
         16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
         16'h03b1, 16'h00df, 16'h03b2, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3,
         16'h03bc, 16'h00b5, 16'h03c4, 16'h03a6, 16'h0398, 16'h03a9, 16'h2126,
         16'h03b4, 16'h221e, 16'h03c6, 16'h2205, 16'h2300, 16'h03b5, 16'h2208,
         16'h2229,
         16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7,
         16'h2248, 16'h00b0, 16'h02da, 16'h030a, 16'h2219, 16'h00b7, 16'h221a,
         16'h207f, 16'h00b2, 16'h25a0, 16'h00a0};
      vals = '{
         8'h22, 8'h27, 8'h2c, 8'h2c, 8'h2d, 8'h2d, 8'h2d, 8'h2d, 8'h2d, 8'h2f,
         8'h41, 8'h41, 8'h41, 8'h41, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49,
         8'h49, 8'h60, 8'h63, 8'h7c, 8'h7e, 8'h7e,
         8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
         8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h8f,
         8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99,
         8'h9a, 8'h9b, 8'h9b, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
         8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9,
         8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'hae, 8'hae, 8'hae, 8'hae, 8'haf,
         8'haf,
         8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9,
         8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'hc0, 8'hc1, 8'hc2, 8'hc3,
         8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd,
         8'hce, 8'hcf, 8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7,
         8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde, 8'hdf,
         8'he0, 8'he1, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he6, 8'he7,
         8'he8, 8'he9, 8'hea, 8'hea, 8'heb, 8'hec, 8'hed, 8'hed, 8'hed, 8'hee,
         8'hee, 8'hef,
         8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf8,
         8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff};
      if (cp < 16'h0080) return cp[7:0];
      for (int i = 0; i < 170; i++) begin
         if (keys[i] == cp) return vals[i];
      end
      return MissCode;
   endfunction

   // one accepted byte: advance the decoder, queue a character if one forms
   task automatic decode_byte(input logic [7:0] b);
      logic [7:0]  first;
      logic [15:0] cp;
      logic        done;
      char_type    c;
      done = 1'b0;
      if (!held_valid) begin
         held_byte  = b;
         held_valid = 1'b1;
      end
      first = held_byte;
      if (b[7] == 1'b0) begin
         cp = {8'h00, b};
         bytes_left = '0;
         done = 1'b1;
      end else if (bytes_left != 3'd0 && b[7:6] == 2'b10) begin
         accum = {accum[9:0], b[5:0]};
         bytes_left = bytes_left - 3'd1;
         cp = accum;
         done = (bytes_left == 3'd0);
      end else begin
         cp = '0;
         if (b[7:5] == 3'b110) begin
            bytes_left = 3'd1; accum = {11'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            bytes_left = 3'd2; accum = {12'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            bytes_left = 3'd3; accum = {13'd0, b[2:0]};
         end else if (b[7:2] == 6'b111110) begin
            bytes_left = 3'd4; accum = {14'd0, b[1:0]};
         end else if (b[7:1] == 7'b1111110) begin
            bytes_left = 3'd5; accum = {15'd0, b[0]};
         end else begin
            bytes_left = '0;
         end
      end
      // zero, noncharacters, byte-order mark and the 0x200a to 0x200f range drop out
      if (done && !(cp == 16'h0000 || cp >= CpNoncharLo || cp == CpBom ||
                    (cp >= CpSpaceLo && cp <= CpSpaceHi))) begin
         c.code_point  = cp;
         c.mapped_code = map_enable ? codepage_of(cp) : first;
         char_queue.push_back(c);
         held_valid = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      char_type want;
      int       errs;
      errs = 0;
      if (reset) begin
         bytes_left = '0;
         accum      = '0;
         held_byte  = '0;
         held_valid = 1'b0;
         char_queue.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // results first: a byte accepted now cannot produce one this edge
         if (rsp.valid && rsp.ready) begin
            if (char_queue.size() == 0) begin
               $display("%0t: unexpected character: code_point %h mapped_code %h",
                        $time, rsp.code_point, rsp.mapped_code);
               errs = errs + 1;
            end else begin
               want = char_queue.pop_front();
               if (want.code_point !== rsp.code_point) begin
                  $display("%0t: code_point mismatch: expected %h actual %h",
                           $time, want.code_point, rsp.code_point);
                  errs = errs + 1;
               end
               if (want.mapped_code !== rsp.mapped_code) begin
                  $display("%0t: mapped_code mismatch: expected %h actual %h",
                           $time, want.mapped_code, rsp.mapped_code);
                  errs = errs + 1;
               end
            end
         end
         if (req.valid && req.ready) decode_byte(req.in_byte);
         fail_count    <= fail_count + errs;
         pending_count <= char_queue.size();
      end
   end
endmodule

// ===== tb/sv/utf8_decode_to_codepage_top_tb.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder testbench
// Drives directed and random UTF-8 byte streams under both mapping settings
// with random idling on both channels and one long result hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_decode_to_codepage_top_tb;
   import u8d_pkg::*;

   localparam int IdleLimit = 2000;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   logic        map_enable;
   logic        send_calm, hold_off;
   int          fail_count, pending_count, idle_cycles;

   u8d_req_if req ();
   u8d_rsp_if rsp ();

   utf8_decode_to_codepage_top u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready));

   utf8_decode_to_codepage_top_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .map_enable(map_enable),
      .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stalls, a calm stretch, and one long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) rsp.ready <= 1'b0;
      else if (send_calm) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(99) >= 24);
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("utf8_decode_to_codepage_top_tb failed");
         $finish;
      end
   end

   task automatic write_map(input logic value);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= RegMapEnable;
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      map_enable  <= value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one byte, idling at random unless calm, and wait for acceptance
   task automatic send_byte(input logic [7:0] b);
      while (!send_calm && $urandom_range(99) < 24) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.in_byte <= b;
      do @(posedge clock); while (!req.ready);
   endtask

   // continuation with random payload, bit 7 set and bit 6 clear
   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   // well-formed sequence of n bytes with random payload
   task automatic send_sequence(input int n);
      logic [7:0] lead;
      case (n)
         1: lead = 8'($urandom_range(127));
         2: lead = 8'hc0 | 8'($urandom_range(31));
         3: lead = 8'he0 | 8'($urandom_range(15));
         4: lead = 8'hf0 | 8'($urandom_range(7));
         5: lead = 8'hf8 | 8'($urandom_range(3));
         default: lead = 8'hfc | 8'($urandom_range(1));
      endcase
      send_byte(lead);
      for (int i = 1; i < n; i++) send_byte(cont_byte());
   endtask

   task automatic send_char(input logic [15:0] cp);
      if (cp < 16'h80) send_byte(cp[7:0]);
      else if (cp < 16'h800) begin
         send_byte({3'b110, cp[10:6]});
         send_byte({2'b10, cp[5:0]});
      end else begin
         send_byte({4'b1110, cp[15:12]});
         send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end
   endtask

   // wait until every predicted character has left and the pipe is empty
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [15:0] picks[8];
      int          r;
      picks = '{16'h00e9, 16'h2591, 16'h00a0, 16'h25a0, 16'h03c0, 16'h20ac,
                16'h1234, 16'h200b};
      for (int k = 0; k < count; k++) begin
         send_calm = (k % 120) >= 90;
         r = $urandom_range(99);
         if (r < 55) send_sequence($urandom_range(1, 4));
         else if (r < 65) send_sequence($urandom_range(5, 6));
         else if (r < 80) send_char(picks[$urandom_range(7)]);
         else if (r < 88) begin
            // broken sequence: lead with too few continuations
            send_byte(8'he0 | 8'($urandom_range(15)));
            send_byte(cont_byte());
         end else send_byte(8'($urandom));
      end
      send_calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      hold_off = 1'b0;
      send_calm = 1'b0;
      map_enable = 1'b1;
      req.valid = 1'b0;
      req.in_byte = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, suppressed values, stray and invalid bytes
      send_byte(8'h00);  send_byte(8'h7f);  send_byte(8'h80);  send_byte(8'hff);
      send_byte(8'hfe);  send_char(16'h00e9); send_char(16'hfeff);
      send_char(16'h200a); send_char(16'h200f); send_char(16'h2009);
      send_char(16'hfffe); send_char(16'hfffd); send_char(16'h1234);
      send_byte(8'he2);  send_byte(8'hc3);  send_byte(8'ha9);
      send_byte(8'hfd);  repeat (5) send_byte(8'hbf);
      send_byte(8'hc1);  send_byte(8'h41);
      drain();

      write_map(1'b0);
      send_char(16'h00a0); send_char(16'h0041); send_byte(8'hff);
      send_char(16'h00e9);
      random_phase(150);
      drain();

      // long hold-off on the result side while bytes keep coming
      write_map(1'b1);
      hold_off = 1'b1;
      fork
         begin
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(25);
      join
      random_phase(150);
      drain();

      write_map(1'b0);
      random_phase(80);
      drain();
      write_map(1'b1);
      random_phase(100);
      drain();

      if (fail_count == 0) $display("utf8_decode_to_codepage_top_tb passed");
      else $display("utf8_decode_to_codepage_top_tb failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/u8d_pkg.sv
rtl/u8d_stream_if.sv
rtl/u8d_decode.sv
rtl/u8d_output.sv
rtl/utf8_decode_to_codepage_top.sv
tb/sv/utf8_decode_to_codepage_top_checker.sv
tb/sv/utf8_decode_to_codepage_top_tb.sv
